[hdl/note_string_parser_assert.svh]
// ============================================================================
// note_string_parser_assert.svh
// Assertion macros for the note string parser checker.
// ============================================================================
`ifndef NOTE_STRING_PARSER_ASSERT_SVH
`define NOTE_STRING_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/nsp_pkg.sv]
// ============================================================================
// nsp_pkg
// Types, character codes and note helpers for the note string parser.
// ============================================================================
package nsp_pkg;

   localparam int OCTAVE_SPAN_DEFAULT = 12;
   localparam int MAX_NOTE_DEFAULT    = 59;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_CASE    = 8'h20;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_G = 8'h67;
   localparam logic [7:0] CHR_LOWER_R = 8'h72;
   localparam logic [7:0] CHR_SHARP   = 8'h23;
   localparam logic [7:0] CHR_PLUS    = 8'h2B;
   localparam logic [7:0] CHR_MINUS   = 8'h2D;
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_NINE    = 8'h39;
   localparam logic [7:0] CHR_TAB     = 8'h09;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_SPACE   = 8'h20;

   // One result as it leaves the block (without the end markers).
   typedef struct packed {
      logic [6:0] note_value;
      logic       is_rest;
      logic       no_note;
   } result_type;

   // All results caused by one input byte.
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;      // second result is present
      logic       done;     // byte was the string's last
   } job_type;

   // Semitone plus one for letters a..g.
   function automatic logic [4:0] letter_semi(input logic [2:0] idx);
      logic [4:0] s;
      case (idx)
         3'd0:    s = 5'd10;
         3'd1:    s = 5'd12;
         3'd2:    s = 5'd1;
         3'd3:    s = 5'd3;
         3'd4:    s = 5'd5;
         3'd5:    s = 5'd6;
         3'd6:    s = 5'd8;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // octave * span + semitone; out of range gives a rest.
   function automatic result_type make_note(input logic [3:0] octave,
                                            input logic [4:0] semi_p1,
                                            input int span, input int max_note);
      logic [8:0] sum;
      logic       ok;
      result_type r;
      sum = 9'(int'(octave) * span + int'(semi_p1));
      ok  = (sum != 9'd0) && ((int'(sum) - 1) <= max_note);
      r.note_value = ok ? 7'(sum - 9'd1) : 7'd0;
      r.is_rest    = !ok;
      r.no_note    = 1'b0;
      return r;
   endfunction

endpackage

[hdl/nsp_front.sv]
// ============================================================================
// nsp_front
// Classifies each byte, tracks the pending note and builds its result job.
// ============================================================================
module nsp_front import nsp_pkg::*; #(
   parameter int OCTAVE_SPAN = OCTAVE_SPAN_DEFAULT,
   parameter int MAX_NOTE    = MAX_NOTE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_string_end,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LETTER = 2'd1;
   localparam logic [1:0] PH_AFTER  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [4:0] semi_ff, semi_in;

   logic [7:0] lc;
   logic       is_space, is_digit, is_acc_up, is_acc_dn, is_letter, is_r;
   logic       pending, cont, consumed;
   logic       c_a, c_r, c_e;
   logic [1:0] phase_mid;
   logic [4:0] semi_mid;
   logic [3:0] digit;
   result_type res_a, res_r, res_e, res_none;
   logic       accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lc        = (req_char_code >= CHR_UPPER_A && req_char_code <= CHR_UPPER_Z) ?
                  req_char_code + CHR_CASE : req_char_code;
      is_space  = req_char_code inside {[CHR_TAB:CHR_CR], CHR_SPACE};
      is_digit  = req_char_code inside {[CHR_ZERO:CHR_NINE]};
      is_acc_up = (req_char_code == CHR_SHARP) || (req_char_code == CHR_PLUS);
      is_acc_dn = (req_char_code == CHR_MINUS);
      is_letter = lc inside {[CHR_LOWER_A:CHR_LOWER_G]};
      is_r      = (lc == CHR_LOWER_R);
      digit     = is_digit ? 4'(req_char_code - CHR_ZERO) : 4'd0;

      pending   = 1'b0;
      cont      = 1'b0;
      phase_mid = PH_IDLE;
      semi_mid  = semi_ff;
      case (phase_ff)
         PH_LETTER: begin
            pending = 1'b1;
            cont    = is_acc_up || is_acc_dn || is_space;
            if (cont) begin
               phase_mid = PH_AFTER;
            end
            if (is_acc_up) begin
               semi_mid = semi_ff + 5'd1;
            end else if (is_acc_dn) begin
               semi_mid = semi_ff - 5'd1;
            end
         end
         PH_AFTER: begin
            pending = 1'b1;
            cont    = is_space;
            if (cont) begin
               phase_mid = PH_AFTER;
            end
         end
         default: begin
            pending = 1'b0;
         end
      endcase

      // pending note closes on a digit or on any byte that cannot continue it
      c_a      = pending && !cont;
      consumed = cont || (pending && is_digit);
      res_a    = make_note(digit, semi_ff, OCTAVE_SPAN, MAX_NOTE);

      c_r = !consumed && !is_space && is_r;
      if (!consumed && !is_space && is_letter) begin
         semi_mid  = letter_semi(3'(lc - CHR_LOWER_A));
         phase_mid = PH_LETTER;
      end

      c_e = req_string_end && (phase_mid == PH_LETTER || phase_mid == PH_AFTER);

      phase_in = req_string_end ? PH_IDLE : phase_mid;
      semi_in  = semi_mid;

      res_r      = '{note_value: 7'd0, is_rest: 1'b1, no_note: 1'b0};
      res_none   = '{note_value: 7'd0, is_rest: 1'b0, no_note: 1'b1};
      res_e      = make_note(4'd0, semi_mid, OCTAVE_SPAN, MAX_NOTE);

      q_job.first  = c_a ? res_a : (c_r ? res_r : (c_e ? res_e : res_none));
      q_job.second = (c_a && c_r) ? res_r : res_e;
      q_job.two    = (c_a && c_r) || (c_a && c_e) || (c_r && c_e);
      q_job.done   = req_string_end;
      q_push       = accept && (c_a || c_r || c_e || req_string_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         semi_ff  <= 5'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         semi_ff  <= semi_in;
      end
   end

endmodule

[hdl/nsp_queue.sv]
// ============================================================================
// nsp_queue
// Small FIFO of result jobs between the front and back parts.
// ============================================================================
module nsp_queue import nsp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type        slots_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slots_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

endmodule

[hdl/nsp_back.sv]
// ============================================================================
// nsp_back
// Holds one job in its output register and hands out its results in order.
// ============================================================================
module nsp_back import nsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_note_value,
   output logic       rsp_is_rest,
   output logic       rsp_no_note,
   output logic       rsp_string_done,
   output logic       rsp_last_of_item
);

   logic    busy_ff, busy_in;
   logic    idx_ff, idx_in;
   job_type job_ff;
   logic    last, load;
   result_type cur;

   always_comb begin
      cur   = idx_ff ? job_ff.second : job_ff.first;
      last  = !job_ff.two || idx_ff;
      // free slot, or the last result leaves this cycle
      load  = !q_empty && (!busy_ff || (rsp_ready && last));
      q_pop = load;

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = 1'b1;
         end
      end
   end

   assign rsp_valid        = busy_ff;
   assign rsp_note_value   = cur.note_value;
   assign rsp_is_rest      = cur.is_rest;
   assign rsp_no_note      = cur.no_note;
   assign rsp_last_of_item = last;
   assign rsp_string_done  = last && job_ff.done;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= q_head;
      end
   end

endmodule

[hdl/note_string_parser.sv]
// ============================================================================
// note_string_parser
// Streams a note string byte by byte and returns note, rest or end entries.
// ============================================================================
// A result passes the job queue and then the output register before rsp_valid.
// Throughput: one byte per cycle while each byte yields at most one result
//   and rsp_ready is high; a two-result byte holds the output register until
//   both are taken, and the QUEUE_DEPTH-entry job queue absorbs that until full.
// Reset: synchronous, active high; clears the parse phase, pending semitone,
//   queue pointers and the output valid.
module note_string_parser import nsp_pkg::*; #(
   parameter int OCTAVE_SPAN = OCTAVE_SPAN_DEFAULT,
   parameter int MAX_NOTE    = MAX_NOTE_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_note_value,
   output logic       rsp_is_rest,
   output logic       rsp_no_note,
   output logic       rsp_string_done,
   output logic       rsp_last_of_item
);

   // Front to queue: one job per byte that yields any result.
   logic    q_push, q_full, q_pop, q_empty;
   job_type push_job, head_job;

   // Front: byte classification and note state. Ready only follows the
   // queue's fill level, so bytes flow on during a back stall until the queue fills.
   nsp_front #(
      .OCTAVE_SPAN (OCTAVE_SPAN),
      .MAX_NOTE    (MAX_NOTE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_string_end (req_string_end),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   nsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   // Back: output register, one result per handshake, marks the last result
   // of each byte and the end of string.
   nsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (head_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_note_value   (rsp_note_value),
      .rsp_is_rest      (rsp_is_rest),
      .rsp_no_note      (rsp_no_note),
      .rsp_string_done  (rsp_string_done),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

[hdl/nsp_checker.sv]
// ============================================================================
// nsp_checker
// Port-level checks on the note string parser's result channel.
// ============================================================================
`include "note_string_parser_assert.svh"

module nsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_note_value,
   input logic       rsp_is_rest,
   input logic       rsp_no_note,
   input logic       rsp_string_done,
   input logic       rsp_last_of_item
);

   `NSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_note_value, rsp_is_rest, rsp_no_note, rsp_string_done, rsp_last_of_item}), "stalled item changed")
   `NSP_ASSERT_NOW(a_zero_value, clock, reset, rsp_valid && (rsp_is_rest || rsp_no_note), rsp_note_value == 7'd0, "rest or empty entry with nonzero note")
   `NSP_ASSERT_NOW(a_empty_ends, clock, reset, rsp_valid && rsp_no_note, rsp_string_done && rsp_last_of_item && !rsp_is_rest, "empty entry not at string end")
   `NSP_ASSERT_NOW(a_done_last, clock, reset, rsp_valid && rsp_string_done, rsp_last_of_item, "string end before last result of byte")

endmodule

bind note_string_parser nsp_checker u_nsp_checker (.*);

[bench/note_string_parser_tb.sv]
// ============================================================================
// note_string_parser_tb
// Self-checking bench for the note string parser. A short directed table hits
// letters, accidentals, whitespace, octave digits, rests, interrupted notes,
// string ends and stray bytes, then random note phrases mixed with noise
// follow. Every result is compared against an in-bench parse of the same
// bytes. Both handshakes idle at random, and the result side holds off once
// long enough to back the block up into its input.
// ============================================================================
module note_string_parser_tb import nsp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OCTAVE_SPAN    = OCTAVE_SPAN_DEFAULT;
   localparam int MAX_NOTE       = MAX_NOTE_DEFAULT;
   localparam int RANDOM_ITEMS   = 500;
   localparam int HOLD_AFTER     = 150;   // bytes taken before the long stall
   localparam int HOLD_CYCLES    = 80;
   localparam int TAIL_CYCLES    = 12;    // margin for any result still in flight
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SHOWN_ERRORS   = 10;

   // semitone of letters a..g
   localparam int LETTER_SEMIS [7] = '{9, 11, 0, 2, 4, 5, 7};

   // bench parse phase
   localparam logic [1:0] SCAN_IDLE   = 2'd0;
   localparam logic [1:0] SCAN_LETTER = 2'd1;   // letter seen, accidental may follow
   localparam logic [1:0] SCAN_AFTER  = 2'd2;   // past the accidental slot

   // one result as seen on the rsp_ side
   typedef struct packed {
      logic [6:0] note_value;
      logic       is_rest;
      logic       no_note;
      logic       string_done;
      logic       last_of_item;
   } entry_type;

   // one row of the directed table; pinned rows carry a hand-typed result
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       pinned;
      entry_type  pin;
   } row_type;

   localparam entry_type NO_PIN     = '0;
   localparam entry_type LONE_REST  = '{7'd0, 1'b1, 1'b0, 1'b0, 1'b1};
   localparam entry_type EMPTY_END  = '{7'd0, 1'b0, 1'b1, 1'b1, 1'b1};
   localparam entry_type NOTE_A4    = '{7'd57, 1'b0, 1'b0, 1'b0, 1'b1};
   localparam entry_type NOTE_F_END = '{7'd5, 1'b0, 1'b0, 1'b1, 1'b1};

   // Directed table. Unpinned rows are checked against the parse below.
   localparam row_type DIRECTED [25] = '{
      '{"r",       1'b0, 1'b1, LONE_REST},   // bare rest
      '{8'h00,     1'b1, 1'b1, EMPTY_END},   // string ends on a dropped byte
      '{"C",       1'b0, 1'b0, NO_PIN},      // upper case letter
      '{"-",       1'b0, 1'b0, NO_PIN},      // flat on C, below zero
      '{"0",       1'b0, 1'b0, NO_PIN},      //   octave 0 -> rest
      '{"b",       1'b0, 1'b0, NO_PIN},
      '{"#",       1'b0, 1'b0, NO_PIN},
      '{"9",       1'b0, 1'b0, NO_PIN},      // top octave, over the range
      '{"a",       1'b0, 1'b0, NO_PIN},
      '{"4",       1'b0, 1'b1, NOTE_A4},
      '{"g",       1'b0, 1'b0, NO_PIN},      // whitespace run before the digit
      '{CHR_SPACE, 1'b0, 1'b0, NO_PIN},
      '{CHR_TAB,   1'b0, 1'b0, NO_PIN},
      '{CHR_CR,    1'b0, 1'b0, NO_PIN},
      '{"3",       1'b0, 1'b0, NO_PIN},
      '{"e",       1'b0, 1'b0, NO_PIN},      // letter cut short by a letter
      '{"d",       1'b0, 1'b0, NO_PIN},
      '{"x",       1'b1, 1'b0, NO_PIN},      // cut short by junk at string end
      '{"f",       1'b1, 1'b1, NOTE_F_END},  // pending note flushed by the end
      '{8'hFF,     1'b1, 1'b1, EMPTY_END},   // high byte, dropped
      '{"c",       1'b0, 1'b0, NO_PIN},      // interrupted by a rest: two results
      '{"R",       1'b0, 1'b0, NO_PIN},
      '{"B",       1'b0, 1'b0, NO_PIN},      // B sharp wraps into the next octave
      '{"+",       1'b0, 1'b0, NO_PIN},
      '{"G",       1'b1, 1'b0, NO_PIN}       // two results on the last byte
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_code;
   logic       req_string_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [6:0] rsp_note_value;
   logic       rsp_is_rest;
   logic       rsp_no_note;
   logic       rsp_string_done;
   logic       rsp_last_of_item;

   // parse state mirrored in the bench
   logic [1:0]  scan_phase;
   logic [4:0]  pend_semi;     // semitone plus one

   entry_type   entries_due [$];
   logic [7:0]  phrase_codes [$];
   int          mismatches;
   int          bytes_taken;
   int          burst_left;
   int          idle_cycles;
   logic        hold_done;
   entry_type   seen;
   entry_type   want;

   note_string_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_string_end   (req_string_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_note_value   (rsp_note_value),
      .rsp_is_rest      (rsp_is_rest),
      .rsp_no_note      (rsp_no_note),
      .rsp_string_done  (rsp_string_done),
      .rsp_last_of_item (rsp_last_of_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Append one result to the list of results due.
   task automatic expect_entry(input entry_type e);
      entries_due = {entries_due, e};
   endtask

   // Append one byte to the phrase under construction.
   task automatic add_code(input logic [7:0] c);
      phrase_codes = {phrase_codes, c};
   endtask

   // Note value of the pending letter at a given octave; out of range is a rest.
   function automatic entry_type octave_entry(input int octave);
      int        note;
      entry_type e;
      note = octave * OCTAVE_SPAN + int'(pend_semi) - 1;
      e = '0;
      if (note >= 0 && note <= MAX_NOTE) begin
         e.note_value = 7'(note);
      end else begin
         e.is_rest = 1'b1;
      end
      return e;
   endfunction

   // Parse one accepted byte and queue the results it should cause. Pinned
   // rows still advance the parse state, but their typed result is queued.
   task automatic parse_note_byte(input logic [7:0] code, input logic last,
                                  input logic pinned, input entry_type pin);
      logic [7:0] lc;
      logic       space;
      logic       digit;
      logic       taken;
      int         octave;
      int         n;
      entry_type  ents [2];
      lc     = (code >= CHR_UPPER_A && code <= CHR_UPPER_Z) ? code + CHR_CASE : code;
      space  = (code >= CHR_TAB && code <= CHR_CR) || code == CHR_SPACE;
      digit  = code >= CHR_ZERO && code <= CHR_NINE;
      octave = digit ? int'(code - CHR_ZERO) : 0;
      taken  = 1'b0;
      n      = 0;
      ents[0] = '0;
      ents[1] = '0;

      // continue or close the pending note
      if (scan_phase == SCAN_LETTER && (code == CHR_SHARP || code == CHR_PLUS)) begin
         pend_semi  = pend_semi + 5'd1;
         scan_phase = SCAN_AFTER;
         taken      = 1'b1;
      end else if (scan_phase == SCAN_LETTER && code == CHR_MINUS) begin
         pend_semi  = pend_semi - 5'd1;
         scan_phase = SCAN_AFTER;
         taken      = 1'b1;
      end else if (scan_phase != SCAN_IDLE && space) begin
         scan_phase = SCAN_AFTER;
         taken      = 1'b1;
      end else if (scan_phase != SCAN_IDLE) begin
         // digit completes the note; anything else flushes it at octave 0
         ents[n]    = octave_entry(octave);
         n++;
         scan_phase = SCAN_IDLE;
         taken      = digit;
      end

      // byte not used by a pending note: look at it afresh
      if (!taken && !space) begin
         if (lc == CHR_LOWER_R) begin
            ents[n] = '0;
            ents[n].is_rest = 1'b1;
            n++;
         end else if (lc >= CHR_LOWER_A && lc <= CHR_LOWER_G) begin
            pend_semi  = 5'(LETTER_SEMIS[lc - CHR_LOWER_A] + 1);
            scan_phase = SCAN_LETTER;
         end
      end

      if (last) begin
         if (scan_phase != SCAN_IDLE) begin
            ents[n] = octave_entry(0);
            n++;
         end
         scan_phase = SCAN_IDLE;
         if (n == 0) begin
            ents[0] = '0;
            ents[0].no_note = 1'b1;
            n = 1;
         end
         ents[n-1].string_done = 1'b1;
      end
      if (n > 0) begin
         ents[n-1].last_of_item = 1'b1;
      end

      if (pinned) begin
         expect_entry(pin);
      end else begin
         for (int i = 0; i < n; i++) begin
            expect_entry(ents[i]);
         end
      end
   endtask

   // Offer one byte; the sender runs in bursts with random gaps between them.
   // Payload is held until the handshake completes.
   task automatic send_byte(input logic [7:0] code, input logic last,
                            input logic pinned, input entry_type pin);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid      <= 1'b1;
      req_char_code  <= code;
      req_string_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_taken++;
      burst_left--;
      parse_note_byte(code, last, pinned, pin);
   endtask

   // Build one random string: mostly well-formed notes with random content,
   // some rests and some stray bytes of any value.
   task automatic build_phrase();
      int         parts;
      int         pick;
      logic [7:0] letter;
      phrase_codes.delete();
      parts = $urandom_range(1, 6);
      repeat (parts) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) begin
            add_code($urandom_range(0, 1) ? "r" : "R");
         end else if (pick < 5) begin
            add_code(8'($urandom_range(0, 255)));
         end else begin
            letter = CHR_LOWER_A + 8'($urandom_range(0, 6));
            if ($urandom_range(0, 1)) begin
               letter = letter - CHR_CASE;
            end
            add_code(letter);
            if ($urandom_range(0, 9) < 4) begin
               case ($urandom_range(0, 2))
                  0:       add_code(CHR_SHARP);
                  1:       add_code(CHR_PLUS);
                  default: add_code(CHR_MINUS);
               endcase
            end
            if ($urandom_range(0, 9) < 3) begin
               repeat ($urandom_range(1, 2)) begin
                  pick = $urandom_range(0, 5);
                  add_code(pick == 5 ? CHR_SPACE : CHR_TAB + 8'(pick));
               end
            end
            if ($urandom_range(0, 9) < 7) begin
               add_code(CHR_ZERO + 8'($urandom_range(0, 9)));
            end
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input entry_type exp_e,
                                input entry_type got_e);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("%0t: %s: expected note=%0d rest=%b none=%b done=%b last=%b",
                  $time, what, exp_e.note_value, exp_e.is_rest, exp_e.no_note,
                  exp_e.string_done, exp_e.last_of_item);
         $display("    got note=%0d rest=%b none=%b done=%b last=%b",
                  got_e.note_value, got_e.is_rest, got_e.no_note,
                  got_e.string_done, got_e.last_of_item);
      end
   endtask

   // Main sequence: reset, directed table, random phrases, drain, verdict.
   initial begin : stimulus
      int i;
      int random_bytes;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_char_code  = 8'h00;
      req_string_end = 1'b0;
      scan_phase     = SCAN_IDLE;
      pend_semi      = 5'd0;
      mismatches     = 0;
      bytes_taken    = 0;
      burst_left     = 0;
      random_bytes   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++) begin
         send_byte(DIRECTED[i].code, DIRECTED[i].last, DIRECTED[i].pinned,
                   DIRECTED[i].pin);
      end

      while (random_bytes < RANDOM_ITEMS) begin
         build_phrase();
         foreach (phrase_codes[k]) begin
            send_byte(phrase_codes[k], k == phrase_codes.size() - 1, 1'b0, NO_PIN);
            random_bytes++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // watchdog covers a block that never drains
      while (entries_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && entries_due.size() == 0) begin
         $display("PASS note_string_parser");
      end else begin
         $display("FAIL note_string_parser");
      end
      $finish;
   end

   // Result side: ready pattern changes mode at random intervals (always
   // ready, coin flip, mostly stalled). Once, after enough traffic, it holds
   // off long enough for the job queue to fill and push back on req_ready.
   initial begin : receiver
      int mode;
      int span;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(16, 64);
         repeat (span) begin
            @(negedge clock);
            if (!hold_done && bytes_taken >= HOLD_AFTER) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Compare each accepted result with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_note_value, rsp_is_rest, rsp_no_note, rsp_string_done,
                  rsp_last_of_item};
         if (entries_due.size() == 0) begin
            flag_mismatch("result with none due", '0, seen);
         end else begin
            want = entries_due.pop_front();
            if (seen.note_value !== want.note_value || seen.is_rest !== want.is_rest ||
                seen.no_note !== want.no_note || seen.string_done !== want.string_done ||
                seen.last_of_item !== want.last_of_item) begin
               flag_mismatch("result mismatch", want, seen);
            end
         end
      end
   end

   // Watchdog: too long without any handshake on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAIL note_string_parser");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
